### hw/rtl/tcw_pkg.sv
// tcw_pkg: shared constants and types of the text console writer.
// Depends on nothing; used by tcw_cursor and text_console_writer.
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int CHAR_W  = 8;
	localparam int CELL_W  = 2 * CHAR_W;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] DEFAULT_COLOUR_RST = 8'd15;

	localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] COLS_A        = ADDR_W'(COLUMNS);

	typedef enum logic [2:0] {
		FN_PUT   = 3'd0,
		FN_READ  = 3'd1,
		FN_LEFT  = 3'd2,
		FN_RIGHT = 3'd3,
		FN_UP    = 3'd4,
		FN_DOWN  = 3'd5,
		FN_CLEAR = 3'd6
	} func_t;

	typedef struct packed {
		logic              go;
		func_t             func;
		logic [CHAR_W-1:0] char_code;
	} cur_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] cur;
		logic [ADDR_W-1:0] nxt;
		logic              scroll;
		logic              put;
	} cur_info_t;

endpackage

### hw/rtl/tcw_cell_ram.sv
// tcw_cell_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/tcw_cursor.sv
// tcw_cursor: cursor register with row/column tracking and move rules.
// Depends on tcw_pkg.
module tcw_cursor (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::cur_cmd_t  cmd,
	output tcw_pkg::cur_info_t info
);
	import tcw_pkg::*;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	logic [ADDR_W-1:0] cursor_q, nxt_cur;
	logic [COL_W-1:0]  col_q, nxt_col;
	logic [ROW_W-1:0]  row_q, nxt_row;
	logic              scroll, put;

	always_comb begin
		nxt_cur = cursor_q;
		nxt_col = col_q;
		nxt_row = row_q;
		scroll  = 1'b0;
		put     = 1'b0;
		unique case (cmd.func)
			FN_PUT: begin
				if (cmd.char_code == CH_NEWLINE) begin
					nxt_col = '0;
					if (row_q == LAST_ROW) begin
						scroll  = 1'b1;
						nxt_cur = LAST_ROW_BASE;
					end else begin
						nxt_row = row_q + ROW_W'(1);
						nxt_cur = cursor_q - ADDR_W'(col_q) + COLS_A;
					end
				end else if (cmd.char_code != CH_RETURN) begin
					put = 1'b1;
					if (col_q == LAST_COL) begin
						nxt_col = '0;
						if (row_q == LAST_ROW) begin
							nxt_row = '0;
							nxt_cur = '0;
						end else begin
							nxt_row = row_q + ROW_W'(1);
							nxt_cur = cursor_q + ADDR_W'(1);
						end
					end else begin
						nxt_col = col_q + COL_W'(1);
						nxt_cur = cursor_q + ADDR_W'(1);
					end
				end
			end
			FN_LEFT: begin
				if (cursor_q != '0) begin
					nxt_cur = cursor_q - ADDR_W'(1);
					if (col_q == '0) begin
						nxt_col = LAST_COL;
						nxt_row = row_q - ROW_W'(1);
					end else begin
						nxt_col = col_q - COL_W'(1);
					end
				end
			end
			FN_RIGHT: begin
				if (cursor_q != LAST_CELL) begin
					nxt_cur = cursor_q + ADDR_W'(1);
					if (col_q == LAST_COL) begin
						nxt_col = '0;
						nxt_row = row_q + ROW_W'(1);
					end else begin
						nxt_col = col_q + COL_W'(1);
					end
				end
			end
			FN_UP: begin
				if (row_q != '0) begin
					nxt_cur = cursor_q - COLS_A;
					nxt_row = row_q - ROW_W'(1);
				end else begin
					nxt_cur = '0;
					nxt_col = '0;
				end
			end
			FN_DOWN: begin
				if (row_q != LAST_ROW) begin
					nxt_cur = cursor_q + COLS_A;
					nxt_row = row_q + ROW_W'(1);
				end else begin
					nxt_cur = LAST_CELL;
					nxt_col = LAST_COL;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cmd.go) begin
			cursor_q <= nxt_cur;
			col_q    <= nxt_col;
			row_q    <= nxt_row;
		end
	end

	assign info.cur    = cursor_q;
	assign info.nxt    = nxt_cur;
	assign info.scroll = scroll;
	assign info.put    = put;

	ap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= LAST_CELL)
		else $error("cursor out of range");

	ap_row_col: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cursor_q) == int'(row_q) * COLUMNS + int'(col_q))
		else $error("cursor and row/column disagree");

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.go |=> $stable(cursor_q))
		else $error("cursor moved without a command");

endmodule

### hw/rtl/text_console_writer.sv
// Text console writer: a COLUMNS x ROWS cell RAM (char low byte, colour high byte)
// and a cursor. One result per command, held in an output register; a new command
// is taken while the writer is idle and that register is empty or is being emptied
// in the same cycle. After reset the RAM is cleared by a sweep over all cells (one
// cell per cycle, single write port) before the first command is taken. Put char,
// carriage return, cursor moves and a read past the last cell register their result
// as they are taken; a read cell in range first waits in ST_READ for the registered
// RAM read. Clear screen sweeps all cells and a newline on the last row makes 1920
// cell copies, a turnaround, then 80 fills through the one write port; both report
// their result at once. Configuration writes are always taken.
// Depends on tcw_pkg, tcw_cell_ram, tcw_cursor.
module text_console_writer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 func,
	input  logic [7:0]                 char_code,
	input  logic [7:0]                 colour,
	input  logic [tcw_pkg::ADDR_W-1:0] cell_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tcw_pkg::ADDR_W-1:0] cursor,
	output logic [7:0]                 cell_char,
	output logic [7:0]                 cell_colour,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [7:0]                 cfg_data
);
	import tcw_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_COPY = 4'b0100,
		ST_FILL = 4'b1000
	} state_t;

	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);

	state_t            st_q;
	logic [ADDR_W-1:0] ptr_q, ptr_s1;
	logic              copy_vld_s1;
	logic [CELL_W-1:0] fill_q;
	logic [7:0]        default_colour_q;
	logic              rd_ok_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] res_cursor_q;
	logic [7:0]        res_char_q, res_colour_q;

	logic              acc, rd_req, in_range, fill_go, res_load;
	func_t             fn;
	cur_cmd_t          cmd;
	cur_info_t         info;

	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [CELL_W-1:0] wdata, rdata;

	assign fn       = func_t'(func);
	assign in_ready = (st_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;
	assign in_range = {1'b0, cell_index} < (ADDR_W + 1)'(CELLS);
	assign rd_req   = acc && (fn == FN_READ) && in_range;
	assign fill_go  = (st_q == ST_FILL) && !copy_vld_s1;
	assign res_load = (acc && !rd_req) || (st_q == ST_READ);
	assign cfg_ready = 1'b1;

	assign cmd.go        = acc;
	assign cmd.func      = fn;
	assign cmd.char_code = char_code;

	tcw_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.info   (info)
	);

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = fill_q;
		if (copy_vld_s1) begin
			we    = 1'b1;
			waddr = ptr_s1;
			wdata = rdata;
		end else if (fill_go) begin
			we = 1'b1;
		end else if (acc && info.put) begin
			we    = 1'b1;
			waddr = info.cur;
			wdata = {colour, char_code};
		end
	end

	assign re    = (st_q == ST_COPY) || rd_req;
	assign raddr = (st_q == ST_COPY) ? ptr_q + COLS_A : cell_index;

	tcw_cell_ram #(
		.DEPTH (CELLS),
		.WIDTH (CELL_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_FILL;
			ptr_q       <= '0;
			fill_q      <= '0;
			copy_vld_s1 <= 1'b0;
			rd_ok_q     <= 1'b0;
		end else begin
			copy_vld_s1 <= (st_q == ST_COPY);
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						rd_ok_q <= in_range;
						if (rd_req) begin
							st_q <= ST_READ;
						end else if (info.scroll) begin
							st_q   <= ST_COPY;
							ptr_q  <= '0;
							fill_q <= {default_colour_q, CH_SPACE};
						end else if (fn == FN_CLEAR) begin
							st_q   <= ST_FILL;
							ptr_q  <= '0;
							fill_q <= {colour, CH_SPACE};
						end
					end
				end
				ST_READ: st_q <= ST_IDLE;
				ST_COPY: begin
					if (ptr_q == COPY_LAST) begin
						st_q  <= ST_FILL;
						ptr_q <= LAST_ROW_BASE;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_FILL: begin
					if (fill_go) begin
						if (ptr_q == LAST_CELL) begin
							st_q <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q + ADDR_W'(1);
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ptr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_colour_q <= DEFAULT_COLOUR_RST;
		end else if (cfg_valid && cfg_ready) begin
			default_colour_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_cursor_q <= acc ? info.nxt : info.cur;
			if ((st_q == ST_READ) && rd_ok_q) begin
				res_char_q   <= rdata[CHAR_W-1:0];
				res_colour_q <= rdata[CELL_W-1:CHAR_W];
			end else begin
				res_char_q   <= '0;
				res_colour_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign cursor      = res_cursor_q;
	assign cell_char   = res_char_q;
	assign cell_colour = res_colour_q;

	ap_copy_addr: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> ptr_s1 < LAST_ROW_BASE)
		else $error("scroll copy outside the upper rows");

	ap_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_READ) |=> out_valid_q)
		else $error("read cell result not registered");

	ap_fill_done: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_go && ptr_q == LAST_CELL) |=> (st_q == ST_IDLE))
		else $error("fill sweep did not end");

endmodule
